// ----- design/rclt_pkg.sv -----
// Package for the callsign route cache: defaults, register indexes and status codes.
// Also holds the key normalization and key check functions.
// Depends on nothing; route_cache_lru_ttl imports it.
package rclt_pkg;

	localparam int ENTRIES_DEF    = 8;
	localparam int ROUTE_BITS_DEF = 32;

	localparam int KEY_BYTES = 8;
	localparam int KEY_W     = 64;
	localparam int TIME_W    = 32;
	localparam int STATUS_W  = 10;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 32;
	localparam int RESULT_W  = 32;

	localparam logic [CFG_IDX_W-1:0] REG_LOOKUP_ENABLED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NEGATIVE_TTL   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RETRY_TTL      = 2'd2;

	localparam logic [TIME_W-1:0] NEGATIVE_TTL_RST = 32'd600000;
	localparam logic [TIME_W-1:0] RETRY_TTL_RST    = 32'd60000;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 10'd200;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 10'd404;

	localparam logic ACTION_LOOKUP = 1'b0;
	localparam logic ACTION_FILL   = 1'b1;

	// Bytes after the first NUL are cleared.
	function automatic logic [KEY_W-1:0] normalize_key(input logic [KEY_W-1:0] raw);
		logic [KEY_W-1:0] k;
		logic live;
		k = '0;
		live = 1'b1;
		for (int i = 0; i < KEY_BYTES; i++) begin
			if (raw[8*i +: 8] == 8'h00)
				live = 1'b0;
			if (live)
				k[8*i +: 8] = raw[8*i +: 8];
		end
		return k;
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	// Three letters then a digit; this also implies at least four characters.
	function automatic logic key_ok(input logic [KEY_W-1:0] k);
		return is_letter(k[7:0]) && is_letter(k[15:8]) && is_letter(k[23:16]) &&
			(k[31:24] >= 8'h30) && (k[31:24] <= 8'h39);
	endfunction

endpackage

// ----- design/route_cache_lru_ttl.sv -----
// Callsign route cache with negative and retry lifetimes and LRU replacement.
// Entries live in one synchronous memory; slot valid bits are flip-flops.
// Depends on rclt_pkg.

// An item is transferred when start is high and busy is low. Every entry is read
// once from the entry memory, one slot a cycle, then the drain and execute states
// follow and done is registered from the execute state; the next item can be
// transferred in the cycle of done; a rejected item skips the scan and drain.
// The result is shown for exactly one cycle with done, and the receiver cannot
// stall it. Configuration writes are taken in any cycle but belong to idle time.
module route_cache_lru_ttl
	import rclt_pkg::*;
#(
	parameter int ENTRIES    = ENTRIES_DEF,
	parameter int ROUTE_BITS = ROUTE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 start,
	output logic                 busy,
	input  logic                 action,
	input  logic [KEY_W-1:0]     callsign_chars,
	input  logic [TIME_W-1:0]    now_ms,
	input  logic                 allow_fetch,
	input  logic [STATUS_W-1:0]  http_status,
	input  logic                 has_route,
	input  logic [31:0]          route_word,
	output logic                 done,
	output logic                 route_found,
	output logic                 fetch_needed,
	output logic                 fetch_failed,
	output logic [RESULT_W-1:0]  route_result,
	output logic                 rejected
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	typedef struct packed {
		logic [KEY_W-1:0]      callsign;
		logic [ROUTE_BITS-1:0] route;
		logic                  negative;
		logic                  transient;
		logic [TIME_W-1:0]     stored_ms;
		logic [TIME_W-1:0]     used_ms;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EXEC  = 4'b1000
	} state_t;

	state_t state_q;

	logic              lookup_enabled_q;
	logic [TIME_W-1:0] neg_ttl_q;
	logic [TIME_W-1:0] retry_ttl_q;

	logic [ENTRIES-1:0] slot_used_q;
	entry_t             mem_q [ENTRIES];
	entry_t             rd_data_s1;
	logic [IDX_W-1:0]   rd_idx_q;
	logic               proc_vld_s1;
	logic [IDX_W-1:0]   proc_idx_s1;

	logic                  action_q;
	logic [KEY_W-1:0]      key_q;
	logic [TIME_W-1:0]     now_q;
	logic                  allow_q;
	logic [STATUS_W-1:0]   status_q;
	logic                  has_route_q;
	logic [ROUTE_BITS-1:0] route_in_q;
	logic                  rej_q;

	logic              hit_q;
	logic [IDX_W-1:0]  hit_idx_q;
	entry_t            hit_ent_q;
	logic [IDX_W-1:0]  vic_idx_q;
	logic [TIME_W-1:0] vic_time_q;

	logic              done_q;
	logic              found_q;
	logic              need_q;
	logic              failed_q;
	logic [RESULT_W-1:0] route_q;
	logic              rej_out_q;

	logic              accept;
	logic [KEY_W-1:0]  key_in;
	logic              free_found;
	logic [IDX_W-1:0]  free_idx;
	logic [TIME_W-1:0] age;
	logic [TIME_W-1:0] ttl;
	logic              fresh;
	logic              parsed;
	logic [IDX_W-1:0]  fill_idx;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_idx;
	entry_t            wr_data;
	entry_t            fill_ent;
	logic [63:0]       hit_route_wide;
	logic [63:0]       fill_route_wide;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign key_in = normalize_key(callsign_chars);

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!slot_used_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	assign age    = now_q - hit_ent_q.stored_ms;
	assign ttl    = hit_ent_q.transient ? retry_ttl_q : neg_ttl_q;
	assign fresh  = hit_q && (!hit_ent_q.negative || (age < ttl));
	assign parsed = (status_q == STATUS_OK) || (status_q == STATUS_NOT_FOUND);

	always_comb begin
		if (hit_q)
			fill_idx = hit_idx_q;
		else if (free_found)
			fill_idx = free_idx;
		else
			fill_idx = vic_idx_q;
	end

	always_comb begin
		fill_ent.callsign   = key_q;
		fill_ent.route      = has_route_q ? route_in_q : '0;
		fill_ent.negative   = !has_route_q;
		fill_ent.transient  = !parsed;
		fill_ent.stored_ms  = now_q;
		fill_ent.used_ms    = now_q;
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = hit_idx_q;
		wr_data = hit_ent_q;
		wr_data.used_ms = now_q;
		if ((state_q == ST_EXEC) && !rej_q) begin
			if (action_q == ACTION_FILL) begin
				wr_en   = 1'b1;
				wr_idx  = fill_idx;
				wr_data = fill_ent;
			end else begin
				wr_en = fresh;
			end
		end
	end

	assign hit_route_wide  = 64'(hit_ent_q.route);
	assign fill_route_wide = 64'(fill_ent.route);

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_idx] <= wr_data;
		rd_data_s1 <= mem_q[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lookup_enabled_q <= 1'b1;
			neg_ttl_q        <= NEGATIVE_TTL_RST;
			retry_ttl_q      <= RETRY_TTL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOOKUP_ENABLED: lookup_enabled_q <= cfg_wdata[0];
				REG_NEGATIVE_TTL:   neg_ttl_q        <= cfg_wdata;
				REG_RETRY_TTL:      retry_ttl_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_used_q <= '0;
			rd_idx_q    <= '0;
			proc_vld_s1 <= 1'b0;
			proc_idx_s1 <= '0;
			hit_q       <= 1'b0;
			hit_idx_q   <= '0;
			hit_ent_q   <= '0;
			vic_idx_q   <= '0;
			vic_time_q  <= '0;
			rej_q       <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q      <= (state_q == ST_EXEC);
			proc_vld_s1 <= (state_q == ST_SCAN);
			proc_idx_s1 <= rd_idx_q;
			if (wr_en)
				slot_used_q[wr_idx] <= 1'b1;
			if (proc_vld_s1 && slot_used_q[proc_idx_s1] && !hit_q &&
				(rd_data_s1.callsign == key_q)) begin
				hit_q     <= 1'b1;
				hit_idx_q <= proc_idx_s1;
				hit_ent_q <= rd_data_s1;
			end
			if (proc_vld_s1) begin
				if ((proc_idx_s1 == '0) || (rd_data_s1.used_ms < vic_time_q)) begin
					vic_idx_q  <= proc_idx_s1;
					vic_time_q <= rd_data_s1.used_ms;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_idx_q <= '0;
						hit_q    <= 1'b0;
						rej_q    <= !lookup_enabled_q || !key_ok(key_in);
						state_q  <= (!lookup_enabled_q || !key_ok(key_in)) ? ST_EXEC : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_idx_q == LAST_IDX)
						state_q <= ST_DRAIN;
					else
						rd_idx_q <= rd_idx_q + 1'b1;
				end
				ST_DRAIN: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q    <= action;
			key_q       <= key_in;
			now_q       <= now_ms;
			allow_q     <= allow_fetch;
			status_q    <= http_status;
			has_route_q <= has_route;
			route_in_q  <= ROUTE_BITS'(route_word);
		end
		if (state_q == ST_EXEC) begin
			found_q   <= 1'b0;
			need_q    <= 1'b0;
			failed_q  <= 1'b0;
			route_q   <= '0;
			rej_out_q <= rej_q;
			if (!rej_q) begin
				if (action_q == ACTION_FILL) begin
					found_q  <= has_route_q;
					failed_q <= !parsed;
					route_q  <= fill_route_wide[RESULT_W-1:0];
				end else if (fresh) begin
					found_q <= !hit_ent_q.negative;
					if (!hit_ent_q.negative)
						route_q <= hit_route_wide[RESULT_W-1:0];
				end else begin
					need_q <= allow_q;
				end
			end
		end
	end

	assign done         = done_q;
	assign route_found  = found_q;
	assign fetch_needed = need_q;
	assign fetch_failed = failed_q;
	assign route_result = route_q;
	assign rejected     = rej_out_q;

endmodule

// ----- design/rclt_checker.sv -----
// Port-level checker for the callsign route cache, bound to route_cache_lru_ttl.
// Depends on rclt_pkg for port widths.
module rclt_checker
	import rclt_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 done,
	input logic                 route_found,
	input logic                 fetch_needed,
	input logic                 fetch_failed,
	input logic [RESULT_W-1:0]  route_result,
	input logic                 rejected
);

	// Each transfer of a result ends the work on its item.
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result shown while the block is still busy");

	a_start_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not make the block busy");

	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rejected) |->
		(!route_found && !fetch_needed && !fetch_failed && (route_result == '0)))
		else $error("rejected item reported other outcomes");

	a_route_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !route_found) |-> (route_result == '0))
		else $error("route returned without a found route");

	a_fetch_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(done && fetch_needed) |-> (!route_found && !fetch_failed))
		else $error("fetch request combined with another outcome");

endmodule

bind route_cache_lru_ttl rclt_checker u_rclt_checker (.*);
